### src/tbr_pkg.sv
// shared constants, types and helpers of the texture box resampler
package tbr_pkg;

    localparam int STORE_TEXELS = 65536;
    localparam int MAX_SIDE     = 1024;

    localparam int SIZE_W    = 11;
    localparam int COORD_W   = 10;
    localparam int IDX_W     = 16;
    localparam int TEXEL_W   = 32;
    localparam int LANES     = 4;
    localparam int LANE_W    = 8;
    localparam int LSUM_W    = LANE_W + 2;
    localparam int FRAC_W    = 16;
    localparam int STEP_W    = SIZE_W + FRAC_W;
    localparam int DEN_W     = SIZE_W + 2;
    localparam int RECIP_SH  = 23;
    localparam int RECIP_W   = RECIP_SH - 1;
    localparam int NUM_W     = 22;
    localparam int TAP_AW    = 21;
    localparam int MUL_A_W   = STEP_W;
    localparam int MUL_B_W   = 24;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(32'h10000);
    localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(32'h1 << (RECIP_SH - 2));
    localparam logic [STEP_W-1:0]  RECIP_NUM   = STEP_W'(32'h1 << RECIP_SH);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_WIDTH   = 2'd0,
        CFG_IN_HEIGHT  = 2'd1,
        CFG_OUT_WIDTH  = 2'd2,
        CFG_OUT_HEIGHT = 2'd3
    } t_cfg_idx;

    // four tap addresses, row-major, before the store range check
    typedef struct packed {
        logic [TAP_AW-1:0] a0;
        logic [TAP_AW-1:0] a1;
        logic [TAP_AW-1:0] a2;
        logic [TAP_AW-1:0] a3;
    } t_taps;

    // zero acts as one, oversize clamps to the largest side
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (32'(v) > 32'(MAX_SIDE)) begin
            return SIZE_W'(MAX_SIDE);
        end
        return v;
    endfunction

endpackage

### src/tbr_store.sv
// single-port synchronous texel memory with registered read data
module tbr_store #(
    parameter int DEPTH = tbr_pkg::STORE_TEXELS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_addr,
    input  logic [tbr_pkg::TEXEL_W-1:0] i_wdata,
    output logic [tbr_pkg::TEXEL_W-1:0] o_rdata
);

    logic [tbr_pkg::TEXEL_W-1:0] r_mem [DEPTH];
    logic [tbr_pkg::TEXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/tbr_div.sv
// restoring divider, one quotient bit per cycle
module tbr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tbr_pkg::STEP_W-1:0] i_dividend,
    input  logic [tbr_pkg::DEN_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [tbr_pkg::STEP_W-1:0] o_quot
);

    localparam int QW    = tbr_pkg::STEP_W;
    localparam int DW    = tbr_pkg::DEN_W;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

    logic [QW-1:0]    r_quot;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DW:0]      w_trial;
    logic             w_ge;
    logic [DW:0]      w_rem_nx;

    always_comb begin
        w_trial  = {r_rem, r_quot[QW-1]};
        w_ge     = (w_trial >= {1'b0, r_den});
        w_rem_nx = w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_run) begin
            r_quot <= {r_quot[QW-2:0], w_ge};
            r_rem  <= w_rem_nx[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### src/tbr_tapgen.sv
// tap address sequencer around one shared multiplier
module tbr_tapgen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tbr_pkg::COORD_W-1:0] i_col,
    input  logic [tbr_pkg::COORD_W-1:0] i_row,
    input  logic [tbr_pkg::STEP_W-1:0]  i_step,
    input  logic [tbr_pkg::RECIP_W-1:0] i_recip,
    input  logic [tbr_pkg::SIZE_W-1:0]  i_in_width,
    input  logic [tbr_pkg::SIZE_W-1:0]  i_in_height,
    input  logic [tbr_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output tbr_pkg::t_taps              o_taps
);

    localparam int SW     = tbr_pkg::SIZE_W;
    localparam int AW     = tbr_pkg::MUL_A_W;
    localparam int BW     = tbr_pkg::MUL_B_W;
    localparam int NW     = tbr_pkg::NUM_W;
    localparam int TW     = tbr_pkg::TAP_AW;
    localparam int FW     = tbr_pkg::FRAC_W;
    localparam int CSUM_W = tbr_pkg::COORD_W + tbr_pkg::STEP_W;
    localparam logic [3:0] K_LAST = 4'd9;

    logic [3:0]                  r_k;
    logic                        r_run;
    logic [tbr_pkg::PROD_W-1:0]  r_prod;
    logic [SW-1:0]               r_c1;
    logic [SW-1:0]               r_c2;
    logic [NW-1:0]               r_n1;
    logic [NW-1:0]               r_n3;
    logic [SW-1:0]               r_q1;
    logic [SW-1:0]               r_q3;
    logic [SW-1:0]               r_r1;
    logic [SW-1:0]               r_r2;
    logic [TW-1:0]               r_base1;
    logic [TW-1:0]               r_base2;

    logic [AW-1:0]               w_a;
    logic [BW-1:0]               w_b;
    logic [tbr_pkg::STEP_W-3:0]  w_quarter;
    logic [tbr_pkg::STEP_W-1:0]  w_three;
    logic [CSUM_W-1:0]           w_csum1;
    logic [CSUM_W-1:0]           w_csum2;
    logic [NW-1:0]               w_n_sel;
    logic [SW-1:0]               w_q_sel;
    logic [NW-1:0]               w_rem;
    logic [SW-1:0]               w_row_fix;

    // operand select per step
    always_comb begin
        unique case (r_k)
            4'd0: begin
                w_a = i_step;
                w_b = BW'(i_col);
            end
            4'd1: begin
                w_a = AW'({i_row, 2'b01});
                w_b = BW'(i_in_height);
            end
            4'd2: begin
                w_a = AW'({i_row, 2'b11});
                w_b = BW'(i_in_height);
            end
            4'd3: begin
                w_a = AW'(r_n1);
                w_b = BW'(i_recip);
            end
            4'd4: begin
                w_a = AW'(r_n3);
                w_b = BW'(i_recip);
            end
            4'd5: begin
                w_a = AW'(r_q1);
                w_b = BW'(i_den);
            end
            4'd6: begin
                w_a = AW'(r_q3);
                w_b = BW'(i_den);
            end
            4'd7: begin
                w_a = AW'(r_r1);
                w_b = BW'(i_in_width);
            end
            4'd8: begin
                w_a = AW'(r_r2);
                w_b = BW'(i_in_width);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // quarter and three-quarter column points, row quotient correction
    always_comb begin
        w_quarter = i_step[tbr_pkg::STEP_W-1:2];
        w_three   = tbr_pkg::STEP_W'(w_quarter) + {w_quarter, 1'b0};
        w_csum1   = CSUM_W'(w_quarter) + r_prod[CSUM_W-1:0];
        w_csum2   = CSUM_W'(w_three) + r_prod[CSUM_W-1:0];
        w_n_sel   = (r_k == 4'd6) ? r_n1 : r_n3;
        w_q_sel   = (r_k == 4'd6) ? r_q1 : r_q3;
        w_rem     = w_n_sel - r_prod[NW-1:0];
        w_row_fix = (w_rem >= NW'(i_den)) ? (w_q_sel + SW'(1)) : w_q_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_k   <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_k   <= '0;
        end else if (r_run) begin
            r_k <= r_k + 4'd1;
            if (r_k == K_LAST) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        if (r_run) begin
            unique case (r_k)
                4'd1: begin
                    r_c1 <= w_csum1[FW+SW-1:FW];
                    r_c2 <= w_csum2[FW+SW-1:FW];
                end
                4'd2: r_n1 <= r_prod[NW-1:0];
                4'd3: r_n3 <= r_prod[NW-1:0];
                4'd4: r_q1 <= r_prod[tbr_pkg::RECIP_SH+SW-1:tbr_pkg::RECIP_SH];
                4'd5: r_q3 <= r_prod[tbr_pkg::RECIP_SH+SW-1:tbr_pkg::RECIP_SH];
                4'd6: r_r1 <= w_row_fix;
                4'd7: r_r2 <= w_row_fix;
                4'd8: r_base1 <= r_prod[TW-1:0];
                4'd9: r_base2 <= r_prod[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_done    = r_run && (r_k == K_LAST);
    assign o_taps.a0 = r_base1 + TW'(r_c1);
    assign o_taps.a1 = r_base1 + TW'(r_c2);
    assign o_taps.a2 = r_base2 + TW'(r_c1);
    assign o_taps.a3 = r_base2 + TW'(r_c2);

endmodule

### src/texture_box_resampler.sv
// top level of the four-tap box filter texture resampler
//
// a request is taken at a clock edge where start is high and busy is low. a load
// request (op 0) writes one 32-bit texel into the single-port texel store; a
// load at an index beyond the store is dropped and gives no result. a pixel
// request (op 1) gives exactly one result, shown for one cycle with
// o_pixel_valid high; the receiver cannot stall, so it must take every strobe.
// a pixel outside the output size answers in the next cycle with
// o_out_of_range set and a zero value. an in-range pixel runs through the tap
// address sequencer (one shared multiplier, one product per cycle: column
// points, row numerators, reciprocal row divide with one correction, row
// bases), then four reads of the single-port store and a final lane sum; busy
// drops with its result unless a configuration write is pending.
// every configuration write makes the block recompute the 11.16 column step
// and the row reciprocal on a one-bit-per-cycle divider: busy stays high
// after the last write until both are stored, and requests wait for it. sizes
// of zero act as one and sizes above the maximum side clamp to it. taps whose
// address falls beyond the store read as zero.
module texture_box_resampler #(
    parameter int STORE_TEXELS = tbr_pkg::STORE_TEXELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [tbr_pkg::IDX_W-1:0]     i_texel_index,
    input  logic [tbr_pkg::TEXEL_W-1:0]   i_texel_value,
    input  logic [tbr_pkg::COORD_W-1:0]   i_out_col,
    input  logic [tbr_pkg::COORD_W-1:0]   i_out_row,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [tbr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tbr_pkg::SIZE_W-1:0]    i_cfg_data,
    // result channel
    output logic                          o_pixel_valid,
    output logic [tbr_pkg::TEXEL_W-1:0]   o_pixel_value,
    output logic [tbr_pkg::COORD_W-1:0]   o_pixel_col,
    output logic [tbr_pkg::COORD_W-1:0]   o_pixel_row,
    output logic                          o_out_of_range
);

    localparam int SA_W = $clog2(STORE_TEXELS);
    localparam int SW   = tbr_pkg::SIZE_W;
    localparam int CW   = tbr_pkg::COORD_W;
    localparam int LW   = tbr_pkg::LANE_W;
    localparam int LSW  = tbr_pkg::LSUM_W;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DIV_STEP  = 6'b000010,
        S_DIV_RECIP = 6'b000100,
        S_CALC      = 6'b001000,
        S_READ      = 6'b010000,
        S_SUM       = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration and derived sampling constants
    logic [SW-1:0]                  r_in_width;
    logic [SW-1:0]                  r_in_height;
    logic [SW-1:0]                  r_out_width;
    logic [SW-1:0]                  r_out_height;
    logic                           r_pend;
    logic [tbr_pkg::STEP_W-1:0]     r_step;
    logic [tbr_pkg::RECIP_W-1:0]    r_recip;

    // request context
    logic [CW-1:0]                  r_col;
    logic [CW-1:0]                  r_row;
    logic [1:0]                     r_tap;
    logic                           r_rd_pend;
    logic                           r_rd_zero;
    logic [tbr_pkg::LANES-1:0][LSW-1:0] r_acc;

    // result registers
    logic                           r_out_valid;
    logic [tbr_pkg::TEXEL_W-1:0]    r_out_value;
    logic [CW-1:0]                  r_out_col;
    logic [CW-1:0]                  r_out_row;
    logic                           r_out_oor;

    logic [SW-1:0]                  w_iw;
    logic [SW-1:0]                  w_ih;
    logic [SW-1:0]                  w_ow;
    logic [SW-1:0]                  w_oh;
    logic [tbr_pkg::DEN_W-1:0]      w_den;
    logic                           w_accept;
    logic                           w_load;
    logic                           w_query;
    logic                           w_oor;
    logic                           w_calc_go;
    logic                           w_div_start;
    logic [tbr_pkg::STEP_W-1:0]     w_div_dividend;
    logic [tbr_pkg::DEN_W-1:0]      w_div_divisor;
    logic                           w_div_done;
    logic [tbr_pkg::STEP_W-1:0]     w_div_quot;
    logic                           w_tg_done;
    tbr_pkg::t_taps                 w_taps;
    logic [tbr_pkg::TAP_AW-1:0]     w_tap_addr;
    logic                           w_tap_in;
    logic                           w_mem_we;
    logic                           w_mem_re;
    logic [31:0]                    w_addr_full;
    logic [SA_W-1:0]                w_mem_addr;
    logic [tbr_pkg::TEXEL_W-1:0]    w_rdata;
    logic [tbr_pkg::LANES-1:0][LSW-1:0] w_lane_sum;
    logic [tbr_pkg::TEXEL_W-1:0]    w_avg;

    // effective sizes and request decode
    always_comb begin
        w_iw      = tbr_pkg::eff_size(r_in_width);
        w_ih      = tbr_pkg::eff_size(r_in_height);
        w_ow      = tbr_pkg::eff_size(r_out_width);
        w_oh      = tbr_pkg::eff_size(r_out_height);
        w_den     = {w_oh, 2'b00};
        w_accept  = start && !busy;
        w_load    = w_accept && (i_op == tbr_pkg::OP_LOAD);
        w_query   = w_accept && (i_op == tbr_pkg::OP_QUERY);
        w_oor     = ({1'b0, i_out_col} >= w_ow) || ({1'b0, i_out_row} >= w_oh);
        w_calc_go = w_query && !w_oor;
    end

    assign busy = (r_state != S_IDLE) || r_pend;

    // configuration registers, any write schedules a recompute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width   <= SW'(1);
            r_in_height  <= SW'(1);
            r_out_width  <= SW'(1);
            r_out_height <= SW'(1);
        end else if (i_cfg_we) begin
            unique case (tbr_pkg::t_cfg_idx'(i_cfg_idx))
                tbr_pkg::CFG_IN_WIDTH:   r_in_width   <= i_cfg_data;
                tbr_pkg::CFG_IN_HEIGHT:  r_in_height  <= i_cfg_data;
                tbr_pkg::CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data;
                tbr_pkg::CFG_OUT_HEIGHT: r_out_height <= i_cfg_data;
            endcase
        end
    end

    // divider runs column step first, then the row reciprocal
    always_comb begin
        w_div_start = ((r_state == S_IDLE) && r_pend && !i_cfg_we)
                   || ((r_state == S_DIV_STEP) && w_div_done && !i_cfg_we);
        if (r_state == S_IDLE) begin
            w_div_dividend = {w_iw, tbr_pkg::FRAC_W'(0)};
            w_div_divisor  = tbr_pkg::DEN_W'(w_ow);
        end else begin
            w_div_dividend = tbr_pkg::RECIP_NUM;
            w_div_divisor  = w_den;
        end
    end

    tbr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    tbr_tapgen u_tapgen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_calc_go),
        .i_col       (r_col),
        .i_row       (r_row),
        .i_step      (r_step),
        .i_recip     (r_recip),
        .i_in_width  (w_iw),
        .i_in_height (w_ih),
        .i_den       (w_den),
        .o_done      (w_tg_done),
        .o_taps      (w_taps)
    );

    // store port: loads write, the read phase walks the four taps
    always_comb begin
        unique case (r_tap)
            2'd0: w_tap_addr = w_taps.a0;
            2'd1: w_tap_addr = w_taps.a1;
            2'd2: w_tap_addr = w_taps.a2;
            2'd3: w_tap_addr = w_taps.a3;
        endcase
        w_tap_in    = 32'(w_tap_addr) < 32'(STORE_TEXELS);
        w_mem_we    = w_load && (32'(i_texel_index) < 32'(STORE_TEXELS));
        w_mem_re    = (r_state == S_READ) && w_tap_in;
        w_addr_full = w_mem_we ? 32'(i_texel_index) : 32'(w_tap_addr);
        w_mem_addr  = w_addr_full[SA_W-1:0];
    end

    tbr_store #(
        .DEPTH (STORE_TEXELS),
        .AW    (SA_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (i_texel_value),
        .o_rdata (w_rdata)
    );

    // per-lane running sums, taps beyond the store count as zero
    always_comb begin
        for (int i = 0; i < tbr_pkg::LANES; i++) begin
            w_lane_sum[i] = r_acc[i]
                          + (r_rd_zero ? LSW'(0) : LSW'(w_rdata[i*LW +: LW]));
            w_avg[i*LW +: LW] = w_lane_sum[i][LSW-1:2];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_calc_go) begin
                    n_state = S_CALC;
                end else if (r_pend && !i_cfg_we) begin
                    n_state = S_DIV_STEP;
                end
            end
            S_DIV_STEP: begin
                if (i_cfg_we) begin
                    n_state = S_IDLE;
                end else if (w_div_done) begin
                    n_state = S_DIV_RECIP;
                end
            end
            S_DIV_RECIP: begin
                if (i_cfg_we || w_div_done) begin
                    n_state = S_IDLE;
                end
            end
            S_CALC: begin
                if (w_tg_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_tap == 2'd3) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_step      <= tbr_pkg::STEP_RESET;
            r_recip     <= tbr_pkg::RECIP_RESET;
            r_tap       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= (r_state == S_READ);
            r_out_valid <= (w_query && w_oor) || (r_state == S_SUM);
            if (i_cfg_we) begin
                r_pend <= 1'b1;
            end else if ((r_state == S_IDLE) && r_pend) begin
                r_pend <= 1'b0;
            end
            if ((r_state == S_DIV_STEP) && w_div_done && !i_cfg_we) begin
                r_step <= w_div_quot;
            end
            if ((r_state == S_DIV_RECIP) && w_div_done && !i_cfg_we) begin
                r_recip <= w_div_quot[tbr_pkg::RECIP_W-1:0];
            end
            if (r_state == S_READ) begin
                r_tap <= r_tap + 2'd1;
            end else begin
                r_tap <= '0;
            end
        end
    end

    // request context and result payload
    always_ff @(posedge i_clk) begin
        r_rd_zero <= !w_tap_in;
        if (w_accept) begin
            r_col <= i_out_col;
            r_row <= i_out_row;
            r_acc <= '0;
        end else if (r_rd_pend) begin
            r_acc <= w_lane_sum;
        end
        if (w_query && w_oor) begin
            r_out_value <= '0;
            r_out_col   <= i_out_col;
            r_out_row   <= i_out_row;
            r_out_oor   <= 1'b1;
        end else if (r_state == S_SUM) begin
            r_out_value <= w_avg;
            r_out_col   <= r_col;
            r_out_row   <= r_row;
            r_out_oor   <= 1'b0;
        end
    end

    assign o_pixel_valid  = r_out_valid;
    assign o_pixel_value  = r_out_value;
    assign o_pixel_col    = r_out_col;
    assign o_pixel_row    = r_out_row;
    assign o_out_of_range = r_out_oor;

    // loads never collide with the tap read phase on the single port
    a_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == S_IDLE))
        else $error("store write outside idle");

    a_tapgen_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tg_done |-> (r_state == S_CALC))
        else $error("tap sequencer finished outside calc phase");

    a_read_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> ((r_state == S_READ) || (r_state == S_SUM)))
        else $error("store read data outside read phase");

    a_calc_holds_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_calc_go |=> busy)
        else $error("in-range request did not raise busy");

    a_sum_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |=> (o_pixel_valid && !o_out_of_range))
        else $error("lane sum did not produce a result");

endmodule
